/* rtl/alle_pkg.sv */
// Package for the array linked list engine: request and result payloads,
// request and status codes, and the memory command/response structs.
// No dependencies.
`default_nettype none

package alle_pkg;

  // widest slot index that any supported pool size needs (64 slots)
  localparam int MAX_SLOT_W  = 6;
  // a listing stops after this many results
  localparam int MAX_RESULTS = 32;
  localparam int K_W         = $clog2(MAX_RESULTS);

  localparam logic [1:0] REQ_HEAD  = 2'd0;
  localparam logic [1:0] REQ_AFTER = 2'd1;
  localparam logic [1:0] REQ_TAIL  = 2'd2;
  localparam logic [1:0] REQ_LIST  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] item_value;
    logic [4:0]         after_slot;
  } alle_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         slot_index;
    logic signed [31:0] out_value;
    logic [5:0]         element_count;
    logic               last_result;
  } alle_res_t;

  // one write address shared by the value and link stores
  typedef struct packed {
    logic                  val_we;
    logic                  lnk_we;
    logic [MAX_SLOT_W-1:0] wr_addr;
    logic [31:0]           val_data;
    logic                  lnk_end;
    logic [MAX_SLOT_W-1:0] lnk_next;
    logic                  rd_en;
    logic [MAX_SLOT_W-1:0] rd_addr;
  } alle_mem_cmd_t;

  typedef struct packed {
    logic [31:0]           val;
    logic                  is_end;
    logic [MAX_SLOT_W-1:0] next;
  } alle_mem_rsp_t;

endpackage

`default_nettype wire

/* rtl/array_linked_list_engine_unit.sv */
// Top level of the array linked list engine: sequencer, slot store and
// result output register. Depends on alle_pkg, alle_store, alle_ctrl.
//
//   channel  ports                         direction  payload
//   in       in_valid in_stall in_data     request    alle_req_t
//   out      out_valid out_stall out_data  result     alle_res_t
//
// Head insert, refused insert and empty listing finish in the accepting cycle.
// Insert-after: anchor read, new slot write, anchor relink. Tail insert walks
// from the head (one link read per cycle, bounded by POOL_SLOTS); list-all
// gives one result per cycle unless the output stalls, at most 32. The
// single read port of the slot store sets these walk rates. Reset:
// synchronous, clears head and count, sets the empty flag; slot memories are
// not cleared. A stalled output holds off new requests, relink and listing.
`default_nettype none

module array_linked_list_engine_unit #(
  parameter int POOL_SLOTS = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  alle_pkg::alle_req_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output alle_pkg::alle_res_t out_data
);
  import alle_pkg::*;

  alle_mem_cmd_t mem_cmd;
  alle_mem_rsp_t mem_rsp;
  logic          emit;
  alle_res_t     emit_data;
  logic          out_free;

  logic          out_valid_r, out_valid_nxt;
  alle_res_t     out_data_r, out_data_nxt;

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  alle_ctrl #(
    .SLOTS (POOL_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .emit      (emit),
    .emit_data (emit_data),
    .mem_cmd   (mem_cmd),
    .mem_rsp   (mem_rsp)
  );

  alle_store #(
    .SLOTS (POOL_SLOTS)
  ) u_store (
    .clk (clk),
    .cmd (mem_cmd),
    .rsp (mem_rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/alle_store.sv */
// Slot store: value memory and link/end memory, one write port each and a
// shared registered read port. Depends on alle_pkg.
`default_nettype none

module alle_store #(
  parameter int SLOTS = 32
) (
  input  wire                    clk,
  input  alle_pkg::alle_mem_cmd_t cmd,
  output alle_pkg::alle_mem_rsp_t rsp
);
  import alle_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);

  logic [31:0]       val_mem [SLOTS];
  logic [SLOT_W:0]   lnk_mem [SLOTS];   // {end, next}
  logic [31:0]       val_q_r;
  logic [SLOT_W:0]   lnk_q_r;

  always_ff @(posedge clk) begin
    if (cmd.val_we) begin
      val_mem[cmd.wr_addr[SLOT_W-1:0]] <= cmd.val_data;
    end
    if (cmd.lnk_we) begin
      lnk_mem[cmd.wr_addr[SLOT_W-1:0]] <= {cmd.lnk_end, cmd.lnk_next[SLOT_W-1:0]};
    end
    if (cmd.rd_en) begin
      val_q_r <= val_mem[cmd.rd_addr[SLOT_W-1:0]];
      lnk_q_r <= lnk_mem[cmd.rd_addr[SLOT_W-1:0]];
    end
  end

  assign rsp.val    = val_q_r;
  assign rsp.is_end = lnk_q_r[SLOT_W];
  assign rsp.next   = MAX_SLOT_W'(lnk_q_r[SLOT_W-1:0]);

endmodule

`default_nettype wire

/* rtl/alle_ctrl.sv */
// Request sequencer: list head/count state, link walk and result issue.
// Slots are never released, so the lowest free slot is always the count.
// Depends on alle_pkg.
`default_nettype none

module alle_ctrl #(
  parameter int SLOTS = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  alle_pkg::alle_req_t     in_data,
  output logic                    in_stall,
  input  wire                     out_free,
  output logic                    emit,
  output alle_pkg::alle_res_t     emit_data,
  output alle_pkg::alle_mem_cmd_t mem_cmd,
  input  alle_pkg::alle_mem_rsp_t mem_rsp
);
  import alle_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_AFTER = 3'd1;
  localparam logic [2:0] S_TAIL  = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_LIST  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic              empty_r, empty_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [SLOT_W-1:0] anchor_r, anchor_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [K_W-1:0]    k_r, k_nxt;

  logic              accept;
  logic              full;
  logic              anchor_bad;
  logic [SLOT_W-1:0] new_slot;
  logic [CNT_W-1:0]  count_inc;
  logic [SLOT_W-1:0] rsp_next;

  assign in_stall   = (state_r != S_IDLE) || !out_free;
  assign accept     = in_valid && !in_stall;
  assign full       = (32'(count_r) >= 32'(SLOTS));
  assign anchor_bad = (32'(in_data.after_slot) >= 32'(count_r));
  assign new_slot   = count_r[SLOT_W-1:0];
  assign count_inc  = count_r + CNT_W'(1);
  assign rsp_next   = mem_rsp.next[SLOT_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    empty_nxt  = empty_r;
    count_nxt  = count_r;
    val_nxt    = val_r;
    anchor_nxt = anchor_r;
    cur_nxt    = cur_r;
    k_nxt      = k_r;
    emit       = 1'b0;
    emit_data  = '0;
    emit_data.element_count = 6'(count_r);
    emit_data.last_result   = 1'b1;
    mem_cmd    = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_data.item_value;
          if (in_data.req_type == REQ_LIST) begin
            if (empty_r) begin
              emit             = 1'b1;
              emit_data.status = ST_EMPTY;
            end else begin
              mem_cmd.rd_en   = 1'b1;
              mem_cmd.rd_addr = MAX_SLOT_W'(head_r);
              cur_nxt         = head_r;
              k_nxt           = '0;
              state_nxt       = S_LIST;
            end
          end else if (full) begin
            emit             = 1'b1;
            emit_data.status = ST_FULL;
          end else if (in_data.req_type == REQ_HEAD ||
                       (in_data.req_type == REQ_TAIL && empty_r)) begin
            mem_cmd.val_we   = 1'b1;
            mem_cmd.lnk_we   = 1'b1;
            mem_cmd.wr_addr  = MAX_SLOT_W'(new_slot);
            mem_cmd.val_data = in_data.item_value;
            mem_cmd.lnk_end  = empty_r;
            mem_cmd.lnk_next = MAX_SLOT_W'(head_r);
            head_nxt         = new_slot;
            empty_nxt        = 1'b0;
            count_nxt        = count_inc;
            emit                    = 1'b1;
            emit_data.status        = ST_OK;
            emit_data.slot_index    = 5'(new_slot);
            emit_data.element_count = 6'(count_inc);
          end else if (in_data.req_type == REQ_AFTER) begin
            if (anchor_bad) begin
              emit             = 1'b1;
              emit_data.status = ST_BAD;
            end else begin
              anchor_nxt      = SLOT_W'(in_data.after_slot);
              mem_cmd.rd_en   = 1'b1;
              mem_cmd.rd_addr = MAX_SLOT_W'(in_data.after_slot);
              state_nxt       = S_AFTER;
            end
          end else begin
            // tail insert on a non-empty list: walk from the head
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = MAX_SLOT_W'(head_r);
            cur_nxt         = head_r;
            state_nxt       = S_TAIL;
          end
        end
      end

      S_AFTER: begin
        // new slot inherits the anchor's successor and end mark
        mem_cmd.val_we   = 1'b1;
        mem_cmd.lnk_we   = 1'b1;
        mem_cmd.wr_addr  = MAX_SLOT_W'(new_slot);
        mem_cmd.val_data = val_r;
        mem_cmd.lnk_end  = mem_rsp.is_end;
        mem_cmd.lnk_next = mem_rsp.next;
        state_nxt        = S_LINK;
      end

      S_TAIL: begin
        if (mem_rsp.is_end) begin
          anchor_nxt       = cur_r;
          mem_cmd.val_we   = 1'b1;
          mem_cmd.lnk_we   = 1'b1;
          mem_cmd.wr_addr  = MAX_SLOT_W'(new_slot);
          mem_cmd.val_data = val_r;
          mem_cmd.lnk_end  = 1'b1;
          mem_cmd.lnk_next = mem_rsp.next;
          state_nxt        = S_LINK;
        end else begin
          mem_cmd.rd_en   = 1'b1;
          mem_cmd.rd_addr = mem_rsp.next;
          cur_nxt         = rsp_next;
        end
      end

      S_LINK: begin
        if (out_free) begin
          mem_cmd.lnk_we   = 1'b1;
          mem_cmd.wr_addr  = MAX_SLOT_W'(anchor_r);
          mem_cmd.lnk_end  = 1'b0;
          mem_cmd.lnk_next = MAX_SLOT_W'(new_slot);
          count_nxt        = count_inc;
          emit                    = 1'b1;
          emit_data.status        = ST_OK;
          emit_data.slot_index    = 5'(new_slot);
          emit_data.element_count = 6'(count_inc);
          state_nxt               = S_IDLE;
        end
      end

      S_LIST: begin
        // read data holds while the result waits
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.status      = ST_OK;
          emit_data.slot_index  = 5'(cur_r);
          emit_data.out_value   = mem_rsp.val;
          emit_data.last_result = mem_rsp.is_end || (k_r == K_W'(MAX_RESULTS - 1));
          if (emit_data.last_result) begin
            state_nxt = S_IDLE;
          end else begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = mem_rsp.next;
            cur_nxt         = rsp_next;
            k_nxt           = k_r + K_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      empty_r <= 1'b1;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      empty_r <= empty_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    anchor_r <= anchor_nxt;
    cur_r    <= cur_nxt;
    k_r      <= k_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(SLOTS))
    else $error("slot count above pool size");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r == (count_r == '0))
    else $error("empty flag disagrees with slot count");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result issued into a full output register");

  a_walk_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST || state_r == S_TAIL) |-> (32'(cur_r) < 32'(count_r)))
    else $error("walk reached a free slot");

  a_link_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK && out_free) |=> (state_r == S_IDLE))
    else $error("link commit did not finish the request");

endmodule

`default_nettype wire
